// ===== src/btbt_pkg.sv =====
// btbt_pkg: shared types and constants for the byte taint bitmap tracker
// used by btbt_front, btbt_queue, btbt_back and byte_taint_bitmap_tracker_unit
`default_nettype none

package btbt_pkg;

	localparam int WORD_BITS   = 32;
	localparam int BIT_IDX_W   = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	localparam logic [31:0] MIN_ADDRESS_RESET = 32'd0;
	localparam logic [31:0] MAX_ADDRESS_RESET = 32'd65535;

	// request codes
	localparam logic [1:0] REQ_QUERY = 2'd0;
	localparam logic [1:0] REQ_MARK  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDRESS = 2'd1;

	typedef enum logic [1:0] {
		KIND_RESULT = 2'd0,
		KIND_QUERY  = 2'd1,
		KIND_RUN    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic                 status;
		logic                 set;
		logic [BIT_IDX_W-1:0] lo;
		logic [BIT_IDX_W-1:0] hi;
	} btbt_cmd_t;

endpackage

`default_nettype wire

// ===== src/byte_taint_bitmap_tracker_unit.sv =====
// byte_taint_bitmap_tracker_unit: top level, window registers, front, queue and back
// depends on btbt_pkg, btbt_front, btbt_queue, btbt_back
//
//   channel | beat moves when          | payload
//   in      | in_valid && !in_stall    | req_type, address, length
//   out     | out_valid && !out_stall  | tainted, status
//   cfg     | cfg_valid && cfg_ready   | cfg_index, cfg_data
//
// a query passes the back end as a word read, then a bit select; the front adds 2 stages
// a mark or clear run is issued from the queue, then writes the store words it touches, one per cycle
// after reset a clearing pass writes all WORD_COUNT store words, one a cycle, with in_stall high
// the front keeps accepting while the 2-entry queue has room; a stalled result holds the back
`default_nettype none

module byte_taint_bitmap_tracker_unit #(
	parameter int TRACKED_BYTES = 65536
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  req_type,
	input  wire  [31:0] address,
	input  wire  [16:0] length,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        tainted,
	output logic        status,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import btbt_pkg::*;

	localparam int WORD_COUNT = (TRACKED_BYTES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int Q_W        = $bits(btbt_cmd_t) + 2 * WIDX_W;

	logic [31:0]       min_address_q;
	logic [31:0]       max_address_q;

	logic              clearing;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	btbt_cmd_t         f_cmd;
	logic [WIDX_W-1:0] f_first;
	logic [WIDX_W-1:0] f_last;
	logic [Q_W-1:0]    q_head;
	btbt_cmd_t         q_head_cmd;
	logic [WIDX_W-1:0] q_head_first;
	logic [WIDX_W-1:0] q_head_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_address_q <= MIN_ADDRESS_RESET;
			max_address_q <= MAX_ADDRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_ADDRESS: min_address_q <= cfg_data;
				CFG_MAX_ADDRESS: max_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	btbt_front #(
		.TRACKED_BYTES(TRACKED_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.address    (address),
		.length     (length),
		.min_address(min_address_q),
		.max_address(max_address_q),
		.clearing   (clearing),
		.push       (q_push),
		.full       (q_full),
		.cmd        (f_cmd),
		.word_first (f_first),
		.word_last  (f_last)
	);

	btbt_queue #(
		.W(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data({f_cmd, f_first, f_last}),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_valid),
		.head     (q_head)
	);

	assign {q_head_cmd, q_head_first, q_head_last} = q_head;

	btbt_back #(
		.TRACKED_BYTES(TRACKED_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (q_pop),
		.head_cmd  (q_head_cmd),
		.head_first(q_head_first),
		.head_last (q_head_last),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tainted   (tainted),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!out_valid || !out_stall))
		else $error("command popped while result register blocked");

	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head_cmd.kind == KIND_QUERY) |-> ##2 out_valid)
		else $error("query result missing two cycles after pop");

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!q_pop && !q_valid))
		else $error("command present during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== src/btbt_front.sv =====
// btbt_front: accepts requests, checks the window and turns runs into word ranges
// depends on btbt_pkg
`default_nettype none

module btbt_front #(
	parameter int TRACKED_BYTES = 65536,
	localparam int WORD_COUNT = (TRACKED_BYTES + btbt_pkg::WORD_BITS - 1) / btbt_pkg::WORD_BITS,
	localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [1:0]             req_type,
	input  wire  [31:0]            address,
	input  wire  [16:0]            length,
	input  wire  [31:0]            min_address,
	input  wire  [31:0]            max_address,
	input  wire                    clearing,
	output logic                   push,
	input  wire                    full,
	output btbt_pkg::btbt_cmd_t    cmd,
	output logic [WIDX_W-1:0]      word_first,
	output logic [WIDX_W-1:0]      word_last
);
	import btbt_pkg::*;

	localparam int OFF_W = WIDX_W + BIT_IDX_W;
	localparam int END_W = ((OFF_W > 17) ? OFF_W : 17) + 1;

	logic [32:0]      lim;
	logic [32:0]      top_q;
	logic [OFF_W-1:0] top_off_q;

	logic             v_s1;
	logic [1:0]       req_s1;
	logic [31:0]      addr_s1;
	logic [16:0]      len_s1;

	logic             v_s2;
	logic [1:0]       req_s2;
	logic [16:0]      len_s2;
	logic             in_win_s2;
	logic [OFF_W-1:0] off_s2;

	logic             adv1;
	logic             accept;
	logic [END_W-1:0] end_full;
	logic [OFF_W-1:0] end_off;

	// window top follows the registers
	assign lim = {1'b0, min_address} + 33'(TRACKED_BYTES - 1);

	always_ff @(posedge clk) begin
		top_q     <= (lim < {1'b0, max_address}) ? lim : {1'b0, max_address};
		top_off_q <= OFF_W'(top_q - {1'b0, min_address});
	end

	assign push     = v_s2 && !full;
	assign adv1     = !v_s2 || push;
	assign in_stall = clearing || (v_s1 && !adv1);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_type;
			addr_s1 <= address;
			len_s1  <= length;
		end
		if (adv1) begin
			req_s2    <= req_s1;
			len_s2    <= len_s1;
			in_win_s2 <= (addr_s1 >= min_address) && ({1'b0, addr_s1} <= top_q);
			off_s2    <= OFF_W'(addr_s1 - min_address);
		end
	end

	// run end, clipped at the window top
	always_comb begin
		end_full = END_W'(off_s2) + END_W'(len_s2) - END_W'(1);
		end_off  = (end_full > END_W'(top_off_q)) ? top_off_q : end_full[OFF_W-1:0];

		word_first = off_s2[OFF_W-1:BIT_IDX_W];
		word_last  = end_off[OFF_W-1:BIT_IDX_W];

		cmd.status = 1'b0;
		cmd.set    = (req_s2 == REQ_MARK);
		cmd.lo     = off_s2[BIT_IDX_W-1:0];
		cmd.hi     = end_off[BIT_IDX_W-1:0];
		cmd.kind   = KIND_RESULT;
		if (req_s2 inside {REQ_QUERY, REQ_MARK, REQ_CLEAR}) begin
			if (!in_win_s2) begin
				cmd.status = 1'b1;
			end else if (req_s2 == REQ_QUERY) begin
				cmd.kind = KIND_QUERY;
			end else if (len_s2 != 17'd0) begin
				cmd.kind = KIND_RUN;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/btbt_queue.sv =====
// btbt_queue: short command queue between front and back
// depends on btbt_pkg
`default_nettype none

module btbt_queue #(
	parameter int W = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] push_data,
	output logic         full,
	input  wire          pop,
	output logic         not_empty,
	output logic [W-1:0] head
);
	import btbt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/btbt_back.sv =====
// btbt_back: taint word store, clearing pass, query reads and masked run writes
// depends on btbt_pkg
`default_nettype none

module btbt_back #(
	parameter int TRACKED_BYTES = 65536,
	localparam int WORD_COUNT = (TRACKED_BYTES + btbt_pkg::WORD_BITS - 1) / btbt_pkg::WORD_BITS,
	localparam int WIDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	output logic                   pop,
	input  btbt_pkg::btbt_cmd_t    head_cmd,
	input  wire  [WIDX_W-1:0]      head_first,
	input  wire  [WIDX_W-1:0]      head_last,
	output logic                   clearing,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic                   tainted,
	output logic                   status
);
	import btbt_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_QUERY = 4'b0100,
		ST_RUN   = 4'b1000
	} state_t;

	state_t               state_q;
	logic [WIDX_W-1:0]    w_q;
	logic [WIDX_W-1:0]    we_q;
	logic                 first_q;
	logic [BIT_IDX_W-1:0] lo_q;
	logic [BIT_IDX_W-1:0] hi_q;
	logic                 set_q;
	logic                 out_valid_q;
	logic                 tainted_q;
	logic                 status_q;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rd_q;

	logic                 out_free;
	logic                 run_last;
	logic [BIT_IDX_W-1:0] lo_sel;
	logic [BIT_IDX_W-1:0] hi_sel;
	logic                 wr_en;
	logic [WORD_BITS-1:0] wr_mask;
	logic                 wr_bit;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && q_valid && out_free;
	assign clearing = (state_q == ST_CLEAR);
	assign run_last = (w_q == we_q);

	assign out_valid = out_valid_q;
	assign tainted   = tainted_q;
	assign status    = status_q;

	always_comb begin
		lo_sel = first_q ? lo_q : '0;
		hi_sel = run_last ? hi_q : BIT_IDX_W'(WORD_BITS - 1);
		wr_en  = (state_q == ST_CLEAR) || (state_q == ST_RUN);
		if (state_q == ST_CLEAR) begin
			wr_mask = FULL_WORD;
			wr_bit  = 1'b0;
		end else begin
			wr_mask = (FULL_WORD >> (BIT_IDX_W'(WORD_BITS - 1) - hi_sel)) & (FULL_WORD << lo_sel);
			wr_bit  = set_q;
		end
	end

	// bit-enabled write, registered read
	always_ff @(posedge clk) begin
		for (int i = 0; i < WORD_BITS; i++) begin
			if (wr_en && wr_mask[i]) begin
				mem[w_q][i] <= wr_bit;
			end
		end
		rd_q <= mem[head_first];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			w_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					w_q <= w_q + WIDX_W'(1);
					if (w_q == WIDX_W'(WORD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						case (head_cmd.kind)
							KIND_RESULT: begin
								out_valid_q <= 1'b1;
							end
							KIND_QUERY: begin
								state_q <= ST_QUERY;
							end
							KIND_RUN: begin
								out_valid_q <= 1'b1;
								w_q         <= head_first;
								state_q     <= ST_RUN;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_QUERY: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_RUN: begin
					if (run_last) begin
						state_q <= ST_IDLE;
					end else begin
						w_q <= w_q + WIDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			we_q      <= head_last;
			first_q   <= 1'b1;
			lo_q      <= head_cmd.lo;
			hi_q      <= head_cmd.hi;
			set_q     <= head_cmd.set;
			tainted_q <= 1'b0;
			status_q  <= (head_cmd.kind == KIND_RESULT) ? head_cmd.status : 1'b0;
		end else if (state_q == ST_RUN) begin
			first_q <= 1'b0;
		end else if (state_q == ST_QUERY) begin
			tainted_q <= rd_q[lo_q];
			status_q  <= 1'b0;
		end
	end

endmodule

`default_nettype wire
